/* hw/rtl/generation_tagged_handle_table_assert.svh */
// Assertion macros shared by the handle table RTL.
// Each macro takes a label, the clock, the active-low reset, a condition
// and a consequence.
`ifndef GENERATION_TAGGED_HANDLE_TABLE_ASSERT_SVH
`define GENERATION_TAGGED_HANDLE_TABLE_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define GHT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("handle table: same-cycle check failed");

// The consequence must hold in the cycle after the condition.
`define GHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("handle table: next-cycle check failed");

`endif

/* hw/rtl/ghtab_pkg.sv */
`timescale 1ns / 1ps

package ghtab_pkg;

    // Command codes.
    localparam logic [1:0] CMD_GENERATE = 2'd0;
    localparam logic [1:0] CMD_CLOSE    = 2'd1;
    localparam logic [1:0] CMD_LOOKUP   = 2'd2;
    localparam logic [1:0] CMD_SET      = 2'd3;

    // Status codes.
    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_FULL    = 2'd1;
    localparam logic [1:0] STS_INVALID = 2'd2;

    // Largest generation id; the counter wraps back to one after it.
    localparam logic [14:0] GEN_MAX = 15'h7FFF;

    // Capacity after reset.
    localparam logic [10:0] CAPACITY_RESET = 11'd1024;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic [1:0]  command;
        logic [9:0]  handle_index;
        logic [14:0] handle_id;
        logic        handle_is_alias;
        logic [31:0] object_word;
    } t_request;

    typedef struct packed {
        logic [1:0]  status;
        logic [9:0]  new_index;
        logic [14:0] new_id;
        logic [31:0] found_object;
        logic [10:0] live_count;
        logic [10:0] peak_live;
    } t_result;

endpackage

/* hw/rtl/generation_tagged_handle_table.sv */
`timescale 1ns / 1ps
`include "generation_tagged_handle_table_assert.svh"

// Generation-tagged handle table. A command is taken when start is high and
// busy is low; busy then stays high for one cycle. A command first reads the
// addressed entry from the tag and object RAMs, then checks it, writes it
// back and updates the free head and counters. The result appears on
// o_result for exactly one cycle, marked by o_result_valid, in the cycle in
// which busy falls; it cannot be held off and must be taken when shown.
// A new command may be started in that same cycle. Entries never handed out
// are tracked by a fill mark, so the table is ready right after reset
// without a clearing pass. The capacity register may be written only while
// no command is in progress.
module generation_tagged_handle_table #(
    parameter int TABLE_DEPTH  = 1024,
    parameter int OBJECT_WIDTH = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  ghtab_pkg::t_request i_request,
    output logic                o_result_valid,
    output ghtab_pkg::t_result  o_result,
    input  logic                i_cfg_we,
    input  logic [10:0]         i_cfg_wdata
);

    import ghtab_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int HEAD_W = ADDR_W + 1;
    localparam logic [HEAD_W-1:0] DEPTH_H  = HEAD_W'(TABLE_DEPTH);
    localparam logic [15:0]       DEPTH_16 = 16'(TABLE_DEPTH);
    localparam logic [HEAD_W-1:0] HEAD_ONE = HEAD_W'(1);

    t_state                  r_state;
    t_state                  n_state;
    logic                    w_accept;

    t_request                r_req;
    logic [ADDR_W-1:0]       r_addr;
    logic [10:0]             r_capacity;
    logic [HEAD_W-1:0]       r_free_head;
    logic [HEAD_W-1:0]       n_free_head;
    logic [HEAD_W-1:0]       r_fill;
    logic [HEAD_W-1:0]       n_fill;
    logic [10:0]             r_active;
    logic [10:0]             n_active;
    logic [10:0]             r_peak;
    logic [10:0]             n_peak;
    logic [14:0]             r_gen;
    logic [14:0]             n_gen;
    t_result                 r_result;
    logic                    r_result_valid;
    t_result                 w_res;

    logic [ADDR_W-1:0]       w_raddr;
    logic [15:0]             w_idx16;
    logic [15:0]             w_tag_q;
    logic [OBJECT_WIDTH-1:0] w_obj_q;
    logic                    w_untouched;
    logic [15:0]             w_rd_tag;
    logic [OBJECT_WIDTH-1:0] w_rd_obj;
    logic [63:0]             w_rd_obj64;
    logic [63:0]             w_in_obj64;
    logic [OBJECT_WIDTH-1:0] w_in_obj;
    logic [15:0]             w_eff_cap;
    logic                    w_handle_ok;
    logic                    w_full;
    logic [15:0]             w_next_head16;
    logic                    w_tag_we;
    logic [15:0]             w_tag_wdata;
    logic                    w_obj_we;
    logic [OBJECT_WIDTH-1:0] w_obj_wdata;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_state = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State outputs.
    always_comb begin
        busy     = 1'b0;
        w_accept = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_accept = start;
            end
            ST_EXEC: begin
                busy = 1'b1;
            end
        endcase
    end

    // Read address: the free head for generate, the handle index otherwise.
    assign w_idx16 = 16'(i_request.handle_index);
    assign w_raddr = (i_request.command == CMD_GENERATE) ? r_free_head[ADDR_W-1:0]
                                                         : w_idx16[ADDR_W-1:0];

    ghtab_ram #(
        .WIDTH (16),
        .DEPTH (TABLE_DEPTH)
    ) u_tag_ram (
        .i_clk   (i_clk),
        .i_we    (w_tag_we),
        .i_waddr (r_addr),
        .i_wdata (w_tag_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_tag_q)
    );

    ghtab_ram #(
        .WIDTH (OBJECT_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_obj_ram (
        .i_clk   (i_clk),
        .i_we    (w_obj_we),
        .i_waddr (r_addr),
        .i_wdata (w_obj_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_obj_q)
    );

    // Entries at or above the fill mark still hold their reset contents:
    // a link to the following entry and a zero object.
    assign w_untouched = ({1'b0, r_addr} >= r_fill);
    assign w_rd_tag    = w_untouched ? ~(16'(r_addr)) : w_tag_q;
    assign w_rd_obj    = w_untouched ? '0 : w_obj_q;
    assign w_rd_obj64  = 64'(w_rd_obj);
    assign w_in_obj64  = {32'd0, r_req.object_word};
    assign w_in_obj    = w_in_obj64[OBJECT_WIDTH-1:0];

    // Effective capacity and the checks that depend on it.
    assign w_eff_cap   = ({5'd0, r_capacity} < DEPTH_16) ? {5'd0, r_capacity} : DEPTH_16;
    assign w_handle_ok = !r_req.handle_is_alias && (r_req.handle_id != 15'd0)
                         && (16'(r_req.handle_index) < w_eff_cap)
                         && (w_rd_tag == {1'b0, r_req.handle_id});
    assign w_full      = ({5'd0, r_active} >= w_eff_cap) || (r_free_head >= DEPTH_H);
    assign w_next_head16 = 16'd0 - w_rd_tag;

    // Command execution and write-back.
    always_comb begin
        n_free_head = r_free_head;
        n_fill      = r_fill;
        n_active    = r_active;
        n_peak      = r_peak;
        n_gen       = r_gen;
        w_tag_we    = 1'b0;
        w_tag_wdata = {1'b0, r_gen};
        w_obj_we    = 1'b0;
        w_obj_wdata = w_in_obj;
        w_res       = '0;
        if (r_state == ST_EXEC) begin
            unique case (r_req.command)
                CMD_GENERATE: begin
                    if (w_full) begin
                        w_res.status = STS_FULL;
                    end else begin
                        n_free_head = w_next_head16[HEAD_W-1:0];
                        if (r_free_head >= r_fill) begin
                            n_fill = r_free_head + HEAD_ONE;
                        end
                        w_tag_we    = 1'b1;
                        w_obj_we    = 1'b1;
                        n_active    = r_active + 11'd1;
                        if (n_active > r_peak) begin
                            n_peak = n_active;
                        end
                        w_res.new_index = 10'(r_addr);
                        w_res.new_id    = r_gen;
                        n_gen = (r_gen >= GEN_MAX) ? 15'd1 : r_gen + 15'd1;
                    end
                end
                CMD_CLOSE: begin
                    if (!w_handle_ok) begin
                        w_res.status = STS_INVALID;
                    end else begin
                        w_tag_we    = 1'b1;
                        w_tag_wdata = 16'd0 - 16'(r_free_head);
                        w_obj_we    = 1'b1;
                        w_obj_wdata = '0;
                        n_free_head = {1'b0, r_addr};
                        if (r_active != 11'd0) begin
                            n_active = r_active - 11'd1;
                        end
                    end
                end
                CMD_LOOKUP: begin
                    if (!w_handle_ok) begin
                        w_res.status = STS_INVALID;
                    end else begin
                        w_res.found_object = w_rd_obj64[31:0];
                    end
                end
                CMD_SET: begin
                    if (!w_handle_ok) begin
                        w_res.status = STS_INVALID;
                    end else begin
                        w_obj_we = 1'b1;
                    end
                end
            endcase
        end
        w_res.live_count = n_active;
        w_res.peak_live  = n_peak;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_IDLE;
            r_capacity     <= CAPACITY_RESET;
            r_free_head    <= '0;
            r_fill         <= '0;
            r_active       <= '0;
            r_peak         <= '0;
            r_gen          <= 15'd1;
            r_result_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_free_head    <= n_free_head;
            r_fill         <= n_fill;
            r_active       <= n_active;
            r_peak         <= n_peak;
            r_gen          <= n_gen;
            r_result_valid <= (r_state == ST_EXEC);
            if (i_cfg_we) begin
                r_capacity <= i_cfg_wdata;
            end
        end
    end

    // Request capture on transfer and result register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req  <= i_request;
            r_addr <= w_raddr;
        end
        if (r_state == ST_EXEC) begin
            r_result <= w_res;
        end
    end

    assign o_result_valid = r_result_valid;
    assign o_result       = r_result;

    `GHT_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, w_accept, busy && !w_accept)
    `GHT_ASSERT_NEXT(a_exec_result, i_clk, i_rst_n, busy, o_result_valid && !busy)
    `GHT_ASSERT_IMPLY(a_result_source, i_clk, i_rst_n, o_result_valid, $past(busy))
    `GHT_ASSERT_IMPLY(a_live_le_peak, i_clk, i_rst_n, o_result_valid, o_result.live_count <= o_result.peak_live)
    `GHT_ASSERT_IMPLY(a_head_le_fill, i_clk, i_rst_n, 1'b1, (r_free_head <= r_fill) && (r_fill <= DEPTH_H))

endmodule

/* hw/rtl/ghtab_ram.sv */
`timescale 1ns / 1ps

module ghtab_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // One read port with registered data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
